@@ hw/rtl/eti_pkg.sv @@
// package: widths, register indexes, ease modes and controller/datapath links
`timescale 1ns / 1ps
`default_nettype none

package eti_pkg;

  localparam int TIME_W        = 40;
  localparam int DUR_W         = 24;
  localparam int VAL_W         = 32;
  localparam int MODE_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 40;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_EASE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_VALUE   = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    EASE_LINEAR      = 3'd0,
    EASE_QUAD_IN     = 3'd1,
    EASE_QUAD_OUT    = 3'd2,
    EASE_QUAD_INOUT  = 3'd3,
    EASE_CUBIC_IN    = 3'd4,
    EASE_CUBIC_OUT   = 3'd5,
    EASE_CUBIC_INOUT = 3'd6
  } ease_mode_t;

  localparam ease_mode_t       EASE_MODE_RST = EASE_QUAD_INOUT;
  localparam logic [DUR_W-1:0] DURATION_RST  = 24'd250;

  // one strobe per datapath operation
  typedef struct packed {
    logic capture;
    logic classify;
    logic div_step;
    logic mul_first;
    logic mul_cube;
    logic ease;
    logic mul_interp;
    logic sum;
    logic fin;
  } eti_cmd_t;

  typedef struct packed {
    logic need_div;
    logic cubic;
    logic out_busy;
  } eti_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/eti_channels.sv @@
// valid/ready channel interfaces for frame items and result items
`timescale 1ns / 1ps
`default_nettype none

interface eti_in_if import eti_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] frame_ms;

  modport source(output valid, output frame_ms, input ready);
  modport sink(input valid, input frame_ms, output ready);
endinterface

interface eti_out_if import eti_pkg::*; #(
  parameter int PROG_W = FRAC_BITS_DEF + 1
) ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] out_value;
  logic [PROG_W-1:0]       progress;
  logic                    changed;
  logic                    running;

  modport source(output valid, output out_value, output progress, output changed,
                 output running, input ready);
  modport sink(input valid, input out_value, input progress, input changed,
               input running, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/eti_ctrl.sv @@
// controller: sequences classify, serial divide, multiplies, easing, sum and result load
`timescale 1ns / 1ps
`default_nettype none

module eti_ctrl import eti_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  eti_stat_t stat,
  output eti_cmd_t  cmd
);

  localparam int             CNT_W    = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLASS = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_MUL1  = 9'b000001000,
    S_MUL2  = 9'b000010000,
    S_EASE  = 9'b000100000,
    S_MUL3  = 9'b001000000,
    S_SUM   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = stat.need_div ? S_DIV : S_MUL1;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_first = 1'b1;
        state_nxt     = stat.cubic ? S_MUL2 : S_EASE;
      end
      S_MUL2: begin
        cmd.mul_cube = 1'b1;
        state_nxt    = S_EASE;
      end
      S_EASE: begin
        cmd.ease  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_interp = 1'b1;
        state_nxt      = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/eti_datapath.sv @@
// datapath: config registers, progress divider, shared multiplier, easing, output register
`timescale 1ns / 1ps
`default_nettype none

module eti_datapath import eti_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [TIME_W-1:0]       in_frame,
  input  eti_cmd_t                cmd,
  output eti_stat_t               stat,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_value,
  output logic [FRAC_BITS:0]      out_progress,
  output logic                    out_changed,
  output logic                    out_running
);

  localparam int P_W  = FRAC_BITS + 1;
  localparam int OP_W = FRAC_BITS + 2;
  localparam int A_W  = VAL_W + 2;
  localparam int PR_W = A_W + OP_W;
  localparam int M_W  = 2 * FRAC_BITS + 2;

  localparam logic [P_W-1:0]  ONE_P   = P_W'(1) << FRAC_BITS;
  localparam logic [P_W-1:0]  HALF_P  = P_W'(1) << (FRAC_BITS - 1);
  localparam logic [P_W:0]    TWO_PX  = (P_W + 1)'(2) << FRAC_BITS;
  localparam logic [OP_W-1:0] ONE_OP  = OP_W'(1) << FRAC_BITS;
  localparam logic [OP_W-1:0] TWO_OP  = OP_W'(2) << FRAC_BITS;
  localparam logic [M_W-1:0]  ONE_SQ  = M_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [PR_W-1:0] RND = (PR_W'(1) << FRAC_BITS) - PR_W'(1);

  // configuration
  ease_mode_t              mode_r;
  logic [TIME_W-1:0]       start_time_r;
  logic [DUR_W-1:0]        duration_r;
  logic signed [VAL_W-1:0] start_value_r;
  logic signed [VAL_W-1:0] end_value_r;

  // working registers
  logic [TIME_W-1:0]       frame_r;
  logic [DUR_W-1:0]        rem_r;
  logic [P_W-1:0]          p_r;
  logic [OP_W-1:0]         s_r;
  logic [P_W-1:0]          alpha_r;
  logic signed [PR_W-1:0]  prod_r;
  logic signed [PR_W-1:0]  total_r;

  // history and result
  logic [P_W-1:0]          last_p_r;
  logic                    has_last_r;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [P_W-1:0]          progress_r;
  logic                    changed_r;
  logic                    running_r;

  logic [TIME_W:0]         elapsed;
  logic [DUR_W-1:0]        dur_eff;
  logic                    before_start;
  logic                    at_end;
  logic [DUR_W:0]          rem2;
  logic                    q_bit;
  logic                    half;
  logic [OP_W-1:0]         p_op;
  logic [OP_W-1:0]         q_op;
  logic [OP_W-1:0]         op_a;
  logic [OP_W-1:0]         op_b;
  logic signed [A_W-1:0]   mul_a;
  logic signed [OP_W-1:0]  mul_b;
  logic signed [PR_W-1:0]  mul_res;
  logic [M_W-1:0]          m;
  logic [P_W-1:0]          c;
  logic [M_W-1:0]          m_bias;
  logic [P_W:0]            two_minus_c;
  logic [P_W-1:0]          alpha_nxt;
  logic signed [A_W-1:0]   diff;
  logic signed [PR_W-1:0]  start_scaled;
  logic signed [PR_W-1:0]  val_full;

  // progress classification
  assign elapsed      = {1'b0, frame_r} - {1'b0, start_time_r};
  assign dur_eff      = (duration_r == '0) ? DUR_W'(1) : duration_r;
  assign before_start = elapsed[TIME_W];
  assign at_end       = elapsed[TIME_W-1:0] >= TIME_W'(dur_eff);

  // restoring divide, one quotient bit a step
  assign rem2  = {rem_r, 1'b0};
  assign q_bit = rem2 >= {1'b0, dur_eff};

  // easing operand select
  assign half = p_r < HALF_P;
  assign p_op = OP_W'(p_r);
  assign q_op = (p_op << 1) - ONE_OP;

  always_comb begin
    case (mode_r)
      EASE_QUAD_OUT: begin
        op_a = p_op;
        op_b = TWO_OP - p_op;
      end
      EASE_QUAD_INOUT: begin
        op_a = half ? p_op : q_op;
        op_b = half ? p_op : TWO_OP - q_op;
      end
      EASE_CUBIC_OUT: begin
        op_a = ONE_OP - p_op;
        op_b = ONE_OP - p_op;
      end
      EASE_CUBIC_INOUT: begin
        op_a = half ? (p_op << 1) : TWO_OP - (p_op << 1);
        op_b = half ? (p_op << 1) : TWO_OP - (p_op << 1);
      end
      default: begin
        op_a = p_op;
        op_b = p_op;
      end
    endcase
  end

  assign diff = A_W'(end_value_r) - A_W'(start_value_r);

  // shared multiplier
  always_comb begin
    if (cmd.mul_interp) begin
      mul_a = diff;
      mul_b = $signed(OP_W'(alpha_r));
    end else if (cmd.mul_cube) begin
      mul_a = $signed({{(A_W - OP_W){1'b0}}, prod_r[FRAC_BITS +: OP_W]});
      mul_b = $signed(s_r);
    end else begin
      mul_a = $signed({{(A_W - OP_W){1'b0}}, op_a});
      mul_b = $signed(op_b);
    end
  end

  assign mul_res = mul_a * mul_b;

  // easing curve from the registered product
  assign m           = prod_r[M_W-1:0];
  assign c           = P_W'(m >> FRAC_BITS);
  assign m_bias      = ONE_SQ + m;
  assign two_minus_c = TWO_PX - {1'b0, c};

  always_comb begin
    case (mode_r)
      EASE_QUAD_IN, EASE_QUAD_OUT, EASE_CUBIC_IN: begin
        alpha_nxt = c;
      end
      EASE_QUAD_INOUT: begin
        alpha_nxt = half ? P_W'(m >> (FRAC_BITS - 1)) : P_W'(m_bias >> (FRAC_BITS + 1));
      end
      EASE_CUBIC_OUT: begin
        alpha_nxt = ONE_P - c;
      end
      EASE_CUBIC_INOUT: begin
        alpha_nxt = half ? (c >> 1) : two_minus_c[P_W:1];
      end
      default: begin
        alpha_nxt = p_r;
      end
    endcase
  end

  // interpolation and truncation toward zero
  assign start_scaled = PR_W'(start_value_r) <<< FRAC_BITS;
  assign val_full     = total_r[PR_W-1] ? ((total_r + RND) >>> FRAC_BITS)
                                        : (total_r >>> FRAC_BITS);

  assign stat.need_div = !before_start && !at_end;
  assign stat.cubic    = (mode_r == EASE_CUBIC_IN) || (mode_r == EASE_CUBIC_OUT) ||
                         (mode_r == EASE_CUBIC_INOUT);
  assign stat.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= EASE_MODE_RST;
      start_time_r  <= '0;
      duration_r    <= DURATION_RST;
      start_value_r <= '0;
      end_value_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EASE_MODE:   mode_r        <= ease_mode_t'(cfg_wdata[MODE_W-1:0]);
        REG_START_TIME:  start_time_r  <= cfg_wdata[TIME_W-1:0];
        REG_DURATION:    duration_r    <= cfg_wdata[DUR_W-1:0];
        REG_START_VALUE: start_value_r <= $signed(cfg_wdata[VAL_W-1:0]);
        REG_END_VALUE:   end_value_r   <= $signed(cfg_wdata[VAL_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      frame_r <= in_frame;
    end
    if (cmd.classify) begin
      p_r   <= (!before_start && at_end) ? ONE_P : '0;
      rem_r <= elapsed[DUR_W-1:0];
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? DUR_W'(rem2 - {1'b0, dur_eff}) : rem2[DUR_W-1:0];
      p_r   <= {p_r[FRAC_BITS-1:0], q_bit};
    end
    if (cmd.mul_first) begin
      s_r <= op_a;
    end
    if (cmd.mul_first || cmd.mul_cube || cmd.mul_interp) begin
      prod_r <= mul_res;
    end
    if (cmd.ease) begin
      alpha_r <= alpha_nxt;
    end
    if (cmd.sum) begin
      total_r <= start_scaled + prod_r;
    end
    if (cmd.fin) begin
      out_value_r <= val_full[VAL_W-1:0];
      progress_r  <= p_r;
      changed_r   <= !has_last_r || (p_r != last_p_r);
      running_r   <= !p_r[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_p_r    <= '0;
      has_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fin) begin
        last_p_r    <= p_r;
        has_last_r  <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_progress = progress_r;
  assign out_changed  = changed_r;
  assign out_running  = running_r;

endmodule

`default_nettype wire

@@ hw/rtl/easing_tween_interpolator.sv @@
// top level: easing tween interpolator, controller plus datapath
// each item is accepted, classified, divided bit-serially, multiplied, eased, summed and loaded;
//   frames before the start or past the end skip the divider; cubic modes add a second multiply
// one item is in flight at a time: a new item is taken only once the last one is loaded
// results sit in an output register, so the next item is taken while one waits
// reset: rst_n synchronous active low; config returns to defaults, no previous frame
`timescale 1ns / 1ps
`default_nettype none

module easing_tween_interpolator import eti_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  eti_in_if.sink                in_item,
  eti_out_if.source             out_item
);

  localparam logic [FRAC_BITS:0] ONE_P = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // control/status links between the two halves
  eti_cmd_t  cmd;
  eti_stat_t stat;

  logic                    in_ready;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_value;
  logic [FRAC_BITS:0]      out_progress;
  logic                    out_changed;
  logic                    out_running;

  // sequencer: idle, classify, divide, multiplies, easing, sum, result load
  eti_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_item.valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // arithmetic, config registers, previous-progress history and output register
  eti_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_frame    (in_item.frame_ms),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_item.ready),
    .out_valid   (out_valid),
    .out_value   (out_value),
    .out_progress(out_progress),
    .out_changed (out_changed),
    .out_running (out_running)
  );

  assign in_item.ready      = in_ready;
  assign out_item.valid     = out_valid;
  assign out_item.out_value = out_value;
  assign out_item.progress  = out_progress;
  assign out_item.changed   = out_changed;
  assign out_item.running   = out_running;

  // progress is clamped to one
  a_progress_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid |-> out_item.progress <= ONE_P)
    else $error("progress above one");

  // running follows progress
  a_running_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid |-> out_item.running == (out_item.progress != ONE_P))
    else $error("running flag disagrees with progress");

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |=> !in_item.ready)
    else $error("input taken while an item is in flight");

endmodule

`default_nettype wire
